/* rtl/sskv_pkg.sv */
// Package for the sparse sorted key/value table.
// Holds sizes, command codes and the controller-to-datapath command/status structs.
package sskv_pkg;

  localparam int CAPACITY    = 64;
  localparam int MAX_DIMS    = 4;
  localparam int COORD_WIDTH = 8;

  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_DEFINE = 1'b1;

  localparam logic [2:0] REG_DEFAULT = 3'd0;
  localparam logic [2:0] REG_DIMS    = 3'd1;
  localparam logic [2:0] REG_RANGE0  = 3'd2;
  localparam logic [2:0] REG_RANGE1  = 3'd3;
  localparam logic [2:0] REG_RANGE2  = 3'd4;
  localparam logic [2:0] REG_RANGE3  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic rd_scan;   // issue a memory read at the scan address
    logic rd_below;  // issue a memory read just below the shift pointer
    logic rd_above;  // issue a memory read just above the shift pointer
    logic scan_step; // compare the returned entry and advance the scan
    logic wr_insert; // one insert shift write (or final key write)
    logic wr_update; // overwrite the value at the found position
    logic wr_delete; // one delete shift write
    logic ins_init;  // point the shift pointer at the top of the table
    logic del_init;  // point the shift pointer at the found entry
    logic shift_dn;  // move the shift pointer down by one
    logic shift_up;  // move the shift pointer up by one
    logic cnt_inc;
    logic cnt_dec;
    logic set_drop;
    logic finish;    // fill the output register
  } sskv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_define;
    logic val_is_def;
    logic scan_done;   // scan pointer reached the count
    logic hit_ge;      // returned entry does not precede the key
    logic hit_eq;      // returned entry equals the key
    logic full;
    logic shift_at_pos; // shift pointer equals the insert position
    logic shift_at_end; // shift pointer is at the last held entry
  } sskv_sts_t;

endpackage

/* rtl/sskv_ram.sv */
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
module sskv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sskv_ctrl.sv */
// Controller state machine of the sparse sorted key/value table.
// Depends on sskv_pkg.
module sskv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_full,
  input  sskv_pkg::sskv_sts_t sts,
  output sskv_pkg::sskv_cmd_t cmd
);
  import sskv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_WAIT = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_INSR = 4'd5; // read entry below the shift pointer
  localparam logic [3:0] S_INSW = 4'd6; // wait for that read
  localparam logic [3:0] S_INSM = 4'd7; // write it one place up
  localparam logic [3:0] S_DELR = 4'd8;
  localparam logic [3:0] S_DELW = 4'd9;
  localparam logic [3:0] S_DELM = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.scan_done) begin
          state_next = S_DEC;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_CMP;
      S_CMP: begin
        cmd.scan_step = 1'b1;
        state_next = (sts.hit_ge) ? S_DEC : S_RD;
      end
      S_DEC: begin
        if (!sts.is_define) begin
          state_next = S_DONE;
        end else if (!sts.val_is_def) begin
          if (sts.hit_eq) begin
            cmd.wr_update = 1'b1;
            state_next = S_DONE;
          end else if (sts.full) begin
            cmd.set_drop = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.ins_init = 1'b1;
            state_next = S_INSR;
          end
        end else if (sts.hit_eq) begin
          cmd.del_init = 1'b1;
          state_next = S_DELR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_INSR: begin
        if (sts.shift_at_pos) begin
          cmd.wr_insert = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_below = 1'b1;
          state_next = S_INSW;
        end
      end
      S_INSW: state_next = S_INSM;
      S_INSM: begin
        cmd.wr_insert = 1'b1;
        cmd.shift_dn = 1'b1;
        state_next = S_INSR;
      end
      S_DELR: begin
        if (sts.shift_at_end) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_above = 1'b1;
          state_next = S_DELW;
        end
      end
      S_DELW: state_next = S_DELM;
      S_DELM: begin
        cmd.wr_delete = 1'b1;
        cmd.shift_up = 1'b1;
        state_next = S_DELR;
      end
      S_DONE: begin
        if (!out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/sskv_dp.sv */
// Datapath of the sparse sorted key/value table: request registers, entry
// memory, scan and shift pointers, entry count. Depends on sskv_pkg, sskv_ram.
module sskv_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_cmd,
  input  logic [7:0]          in_coord [4],
  input  logic [31:0]         in_wval,
  input  logic [31:0]         absent_value,
  input  logic [2:0]          dims_in_use,
  input  logic [8:0]          range_dim [4],
  input  sskv_pkg::sskv_cmd_t cmd,
  output sskv_pkg::sskv_sts_t sts,
  output logic [31:0]         res_value,
  output logic                res_found,
  output logic                res_inb,
  output logic                res_drop,
  output logic [6:0]          res_count
);
  import sskv_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int KW   = MAX_DIMS * COORD_WIDTH;
  localparam int EW   = KW + 32;
  localparam int LIMD = (MAX_DIMS < 4) ? MAX_DIMS : 4;

  logic [CW-1:0] count;
  logic [CW-1:0] scan;   // scan pointer, ends at the first not-preceding entry
  logic [CW-1:0] sptr;   // shift pointer
  logic [KW-1:0] key;    // dimension 0 in the top bits
  logic [31:0]   wval;
  logic          is_def_cmd, inb, found, drop;
  logic [31:0]   stored_val;

  logic [AW-1:0] raddr, waddr;
  logic [AW-1:0] rd_addr; // read address held while the read completes
  logic          we;
  logic [EW-1:0] wdata, rdata;

  logic [KW-1:0] key_new;
  logic          inb_new;
  logic [2:0]    deff;

  always_comb begin
    deff = dims_in_use;
    if (deff == 3'd0) deff = 3'd1;
    if (32'(deff) > MAX_DIMS) deff = 3'(MAX_DIMS);
    key_new = '0;
    inb_new = 1'b1;
    for (int i = 0; i < LIMD; i++) begin
      if (i < 32'(deff)) begin
        key_new[KW-1-i*COORD_WIDTH -: COORD_WIDTH] =
          COORD_WIDTH'(in_coord[i] & 8'((1 << COORD_WIDTH) - 1));
        if ({1'b0, in_coord[i] & 8'((1 << COORD_WIDTH) - 1)} >= range_dim[i]) begin
          inb_new = 1'b0;
        end
      end
    end
  end

  // Memory addressing. A read address is held until the next read is issued,
  // so the data returned after the wait cycle belongs to that read.
  always_comb begin
    raddr = rd_addr;
    if (cmd.rd_scan) begin
      raddr = AW'(scan);
    end else if (cmd.rd_below) begin
      raddr = AW'(sptr - CW'(1));
    end else if (cmd.rd_above) begin
      raddr = AW'(sptr + CW'(1));
    end
    we    = 1'b0;
    waddr = AW'(sptr);
    wdata = rdata;
    if (cmd.wr_insert) begin
      we = 1'b1;
      wdata = (sptr == scan) ? {key, wval} : rdata;
    end else if (cmd.wr_update) begin
      we = 1'b1;
      waddr = AW'(scan);
      wdata = {key, wval};
    end else if (cmd.wr_delete) begin
      we = 1'b1;
    end
  end

  sskv_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_addr <= '0;
    end else begin
      rd_addr <= raddr;
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
    if (cmd.load) begin
      key        <= key_new;
      inb        <= inb_new;
      wval       <= in_wval;
      is_def_cmd <= (in_cmd == CMD_DEFINE);
      scan       <= '0;
      found      <= 1'b0;
      drop       <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (rdata[EW-1:32] >= key) begin
        found      <= (rdata[EW-1:32] == key);
        stored_val <= rdata[31:0];
      end else begin
        scan <= scan + CW'(1);
      end
    end
    if (cmd.set_drop) drop <= 1'b1;
    if (cmd.wr_update) stored_val <= wval;
    // Insert shifting starts at the top; delete shifting at the found entry.
    if (cmd.ins_init) sptr <= count;
    if (cmd.del_init) sptr <= scan;
    if (cmd.shift_dn) sptr <= sptr - CW'(1);
    if (cmd.shift_up) sptr <= sptr + CW'(1);
  end

  always_comb begin
    sts.is_define    = is_def_cmd;
    sts.val_is_def   = (wval == absent_value);
    sts.scan_done    = (scan == count);
    sts.hit_ge       = (rdata[EW-1:32] >= key);
    sts.hit_eq       = found;
    sts.full         = (count >= CW'(CAPACITY));
    sts.shift_at_pos = (sptr == scan);
    sts.shift_at_end = (sptr + CW'(1) >= count);
  end

  logic [31:0] val_out;
  always_comb begin
    if (!is_def_cmd) val_out = found ? stored_val : absent_value;
    else if (wval != absent_value && !drop) val_out = wval;
    else val_out = absent_value;
  end

  assign res_value = val_out;
  assign res_found = found;
  assign res_inb   = inb;
  assign res_drop  = drop;
  assign res_count = 7'(count);
endmodule

/* rtl/sparse_sorted_key_value_table.sv */
// Top level of the sparse sorted key/value table.
// Depends on sskv_pkg, sskv_ctrl, sskv_dp, sskv_ram.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata: coord0..coord3, write_value; tuser: cmd
// m_axis    out  tvalid/tready      tdata: read_value, entry_found, in_bounds,
//                                   insert_dropped, entries_held
// cfg       in   cfg_we             cfg_index selects the register, cfg_data
//
// One item at a time. A lookup scans the held entries in order through the
// single memory read port, reading and comparing one entry in turn; an insert
// or delete then moves entries one by one, each with a read and a write. The
// scan stops where the moves begin. Reset (rst, synchronous) empties the
// table; memory contents need no clearing. A stalled result waits in the
// output register.
module sparse_sorted_key_value_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // coord0, coord1, coord2, coord3, write_value
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // read_value, entry_found, in_bounds,
                                     // insert_dropped, entries_held, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sskv_pkg::*;

  logic [31:0] absent_value;
  logic [2:0]  dims_in_use;
  logic [8:0]  range_dim [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      absent_value <= '0;
      dims_in_use  <= 3'd4;
      for (int i = 0; i < 4; i++) range_dim[i] <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT: absent_value <= cfg_data;
        REG_DIMS:    dims_in_use  <= cfg_data[2:0];
        REG_RANGE0:  range_dim[0] <= cfg_data[8:0];
        REG_RANGE1:  range_dim[1] <= cfg_data[8:0];
        REG_RANGE2:  range_dim[2] <= cfg_data[8:0];
        REG_RANGE3:  range_dim[3] <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  sskv_cmd_t cmd;
  sskv_sts_t sts;
  logic [7:0] coords [4];
  logic [31:0] res_value;
  logic res_found, res_inb, res_drop;
  logic [6:0] res_count;

  always_comb begin
    for (int i = 0; i < 4; i++) coords[i] = s_axis_tdata[i*8 +: 8];
  end

  sskv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_full(m_axis_tvalid && !m_axis_tready), .sts(sts), .cmd(cmd)
  );

  sskv_dp u_dp (
    .clk(clk), .rst(rst), .in_cmd(s_axis_tuser), .in_coord(coords),
    .in_wval(s_axis_tdata[63:32]), .absent_value(absent_value),
    .dims_in_use(dims_in_use), .range_dim(range_dim), .cmd(cmd), .sts(sts),
    .res_value(res_value), .res_found(res_found), .res_inb(res_inb),
    .res_drop(res_drop), .res_count(res_count)
  );

  // Output register: filled when an item finishes, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      m_axis_tdata <= {6'd0, res_count, res_drop, res_inb, res_found, res_value};
    end
  end
endmodule
